// ===== rtl/ndrf_pkg.sv =====
package ndrf_pkg;

   localparam int TRAIT_W = 24;
   localparam int ABUND_W = 48;
   localparam int CSR_W   = 48;
   localparam int INDEX_W = 6;
   localparam int SQ_W    = 2 * TRAIT_W;

   localparam logic [CSR_W-1:0] PRECISION_SQ_RESET    = 48'd429497;
   localparam logic [CSR_W-1:0] ABUNDANCE_FLOOR_RESET = 48'd42950;

   typedef enum logic [0:0] {
      CSR_PRECISION_SQ    = 1'b0,
      CSR_ABUNDANCE_FLOOR = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_ISSUE,
      ST_DRAIN,
      ST_CHECK,
      ST_STORE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic overflow;
      logic keep;
      logic is_unique;
   } rsp_flags_type;

endpackage

// ===== rtl/ndrf_ram.sv =====
module ndrf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/near_duplicate_row_filter.sv =====
// Near-duplicate row filter. Trait elements stream in one per transaction
// (tlast closes a row, tuser closes the set and the row). Each completed row
// is compared in turn against the unique rows kept so far in the set: it is a
// duplicate when the sum of squared element differences is below
// (trait count) * precision_squared. Unique rows go to the row store, and one
// result transaction per row reports index, uniqueness, keep (unique and
// abundance above abundance_floor), overflow past MAX_ROWS and set end.
// Elements that do not end a row are taken while the filter is idle. A row
// end walks the kept rows until a match, reading the row's trait count of
// elements from each, and a unique row is then stored as MAX_TRAITS
// elements, zero-padded: the row store is a single-port-read memory with a
// registered read, read one element per cycle through a three-stage difference,
// square and accumulate path that drains before each slot decision.
// Overflow rows skip the walk and the store. The result register lets the next row's
// elements enter while a result waits. No clearing pass is needed.
module near_duplicate_row_filter
   import ndrf_pkg::*;
#(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_TRAITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // trait_value[23:0], abundance[71:24]
   input  logic        req_tlast,   // row_end
   input  logic        req_tuser,   // set_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // row_index[5:0], zero[7:6]
   output logic        rsp_tlast,   // set_done
   output logic [2:0]  rsp_tuser,   // is_unique[0], keep[1], overflow[2]
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [47:0] csr_wdata
);

   localparam int DEPTH  = MAX_ROWS * MAX_TRAITS;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TCNT_W = $clog2(MAX_TRAITS + 1);
   localparam int TIDX_W = (MAX_TRAITS > 1) ? $clog2(MAX_TRAITS) : 1;
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int ACC_W  = SQ_W + TCNT_W;

   state_type state_ff, state_in;

   logic [CSR_W-1:0]   prec_ff, floor_ff;
   logic [TRAIT_W-1:0] pend_ff [MAX_TRAITS];
   logic [TCNT_W-1:0]  elem_cnt_ff, n_ff, iss_ff;
   logic [RCNT_W-1:0]  row_cnt_ff, kept_cnt_ff, slot_ff;
   logic [AW-1:0]      base_ff, kept_base_ff;
   logic [ACC_W-1:0]   thresh_ff, sum_ff;
   logic               over_ff, unique_ff, abund_gt_ff, last_ff;

   logic               v1_ff, v2_ff, v3_ff;
   logic [TIDX_W-1:0]  i1_ff;
   logic [TRAIT_W-1:0] diff_ff;
   logic [SQ_W-1:0]    sq_ff;

   logic               rsp_valid_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   rsp_flags_type      rsp_flags_ff;
   logic               rsp_last_ff;

   logic               req_fire, row_done, load_rsp;
   logic [TRAIT_W-1:0] trait_value;
   logic [ABUND_W-1:0] abundance;
   logic [TCNT_W-1:0]  elem_cnt_in;
   logic               last_issue, last_store, slot_last, near;
   logic [TIDX_W-1:0]  pidx;
   logic [TRAIT_W-1:0] pend_rd, mem_rd;
   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [TRAIT_W-1:0] mem_wdata;

   assign trait_value = req_tdata[TRAIT_W-1:0];
   assign abundance   = req_tdata[TRAIT_W +: ABUND_W];
   assign req_fire    = req_tvalid && req_tready;
   assign row_done    = req_tlast || req_tuser;

   assign last_issue = (TCNT_W'(iss_ff + 1'b1) == n_ff);
   assign last_store = (iss_ff == TCNT_W'(MAX_TRAITS - 1));
   assign slot_last  = (RCNT_W'(slot_ff + 1'b1) == kept_cnt_ff);
   assign near       = (sum_ff < thresh_ff);
   assign load_rsp   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      elem_cnt_in = elem_cnt_ff;
      if (elem_cnt_ff < TCNT_W'(MAX_TRAITS)) begin
         elem_cnt_in = elem_cnt_ff + 1'b1;
      end
   end

   assign pidx    = (state_ff == ST_STORE) ? iss_ff[TIDX_W-1:0] : i1_ff;
   assign pend_rd = pend_ff[pidx];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && row_done) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (over_ff) begin
               state_in = ST_DONE;
            end else if (kept_cnt_ff == '0) begin
               state_in = ST_STORE;
            end else begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (near) begin
               state_in = ST_DONE;
            end else if (slot_last) begin
               state_in = ST_STORE;
            end else begin
               state_in = ST_ISSUE;
            end
         end
         ST_STORE: begin
            if (last_store) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      mem_re     = 1'b0;
      mem_we     = 1'b0;
      mem_raddr  = AW'(base_ff + AW'(iss_ff));
      mem_waddr  = AW'(kept_base_ff + AW'(iss_ff));
      mem_wdata  = (iss_ff < n_ff) ? pend_rd : '0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_ISSUE: mem_re     = 1'b1;
         ST_STORE: mem_we     = 1'b1;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prec_ff      <= PRECISION_SQ_RESET;
         floor_ff     <= ABUNDANCE_FLOOR_RESET;
         elem_cnt_ff  <= '0;
         row_cnt_ff   <= '0;
         kept_cnt_ff  <= '0;
         kept_base_ff <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            if (csr_index == CSR_PRECISION_SQ) begin
               prec_ff <= csr_wdata;
            end
            if (csr_index == CSR_ABUNDANCE_FLOOR) begin
               floor_ff <= csr_wdata;
            end
         end
         if (req_fire) begin
            elem_cnt_ff <= row_done ? '0 : elem_cnt_in;
         end
         v1_ff <= mem_re;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (load_rsp) begin
            if (last_ff) begin
               row_cnt_ff   <= '0;
               kept_cnt_ff  <= '0;
               kept_base_ff <= '0;
            end else begin
               if (!over_ff) begin
                  row_cnt_ff <= row_cnt_ff + 1'b1;
               end
               if (unique_ff) begin
                  kept_cnt_ff  <= kept_cnt_ff + 1'b1;
                  kept_base_ff <= AW'(kept_base_ff + AW'(MAX_TRAITS));
               end
            end
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (elem_cnt_ff < TCNT_W'(MAX_TRAITS)) begin
            pend_ff[elem_cnt_ff[TIDX_W-1:0]] <= trait_value;
         end
         if (row_done) begin
            n_ff        <= elem_cnt_in;
            over_ff     <= (row_cnt_ff == RCNT_W'(MAX_ROWS));
            unique_ff   <= (row_cnt_ff != RCNT_W'(MAX_ROWS));
            abund_gt_ff <= (abundance > floor_ff);
            last_ff     <= req_tuser;
         end
      end
      if (state_ff == ST_PREP) begin
         thresh_ff <= ACC_W'(n_ff) * ACC_W'(prec_ff);
         slot_ff   <= '0;
         base_ff   <= '0;
         iss_ff    <= '0;
         sum_ff    <= '0;
      end
      if (state_ff == ST_ISSUE || state_ff == ST_STORE) begin
         iss_ff <= (state_ff == ST_ISSUE && last_issue) ? '0 : TCNT_W'(iss_ff + 1'b1);
      end
      if (state_ff == ST_CHECK) begin
         if (near) begin
            unique_ff <= 1'b0;
         end
         slot_ff <= RCNT_W'(slot_ff + 1'b1);
         base_ff <= AW'(base_ff + AW'(MAX_TRAITS));
         iss_ff  <= '0;
         sum_ff  <= '0;
      end else if (v3_ff) begin
         sum_ff <= ACC_W'(sum_ff + ACC_W'(sq_ff));
      end
      i1_ff   <= iss_ff[TIDX_W-1:0];
      diff_ff <= (pend_rd >= mem_rd) ? (pend_rd - mem_rd) : (mem_rd - pend_rd);
      sq_ff   <= SQ_W'(diff_ff) * SQ_W'(diff_ff);
      if (load_rsp) begin
         rsp_index_ff           <= over_ff ? '0 : INDEX_W'(row_cnt_ff);
         rsp_flags_ff.is_unique <= unique_ff;
         rsp_flags_ff.keep      <= unique_ff && abund_gt_ff;
         rsp_flags_ff.overflow  <= over_ff;
         rsp_last_ff            <= last_ff;
      end
   end

   ndrf_ram #(
      .WIDTH (TRAIT_W),
      .DEPTH (DEPTH)
   ) u_kept_rows (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8 - INDEX_W){1'b0}}, rsp_index_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_flags_ff;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import ndrf_pkg::*;

   localparam int MAX_ROWS     = 64;
   localparam int MAX_TRAITS   = 8;
   localparam int SETTLE_CYCLES = 32;
   localparam int TAIL_CYCLES   = 64;
   localparam int PHASE_ITEMS   = 120;

   typedef struct packed {
      logic [INDEX_W-1:0] row_index;
      logic               is_unique;
      logic               keep;
      logic               overflow;
      logic               set_done;
   } row_verdict_type;

   typedef struct {
      logic [TRAIT_W-1:0] trait;
      logic [ABUND_W-1:0] abund;
      bit                 row_end;
      bit                 set_end;
      bit                 typed;
      row_verdict_type    verdict;
   } script_step_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [71:0]        req_tdata = '0;
   logic               req_tlast = 1'b0;
   logic               req_tuser = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;
   logic               rsp_tlast;
   logic [2:0]         rsp_tuser;
   logic               csr_we = 1'b0;
   logic               csr_index = 1'b0;
   logic [CSR_W-1:0]   csr_wdata = '0;

   // filter model state
   logic [TRAIT_W-1:0] pend_row [MAX_TRAITS];
   logic [TRAIT_W-1:0] kept_store [MAX_ROWS][MAX_TRAITS];
   int                 kept_n;
   int                 rows_in_set;
   int                 elems_in_row;
   logic [CSR_W-1:0]   precision_sq;
   logic [CSR_W-1:0]   abundance_floor;

   row_verdict_type    verdicts_due [$];
   script_step_type    script [$];
   row_verdict_type    seen_verdict;
   row_verdict_type    want_verdict;

   bit                 lull_on = 1'b1;
   int                 stall_left = 0;
   int                 errors = 0;
   int                 verdicts_checked = 0;
   int                 overflows_seen = 0;
   int                 elements_sent = 0;
   int                 sets_sent = 0;

   near_duplicate_row_filter #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_TRAITS (MAX_TRAITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   initial begin
      precision_sq    = PRECISION_SQ_RESET;
      abundance_floor = ABUNDANCE_FLOOR_RESET;
      kept_n          = 0;
      rows_in_set     = 0;
      elems_in_row    = 0;
      for (int i = 0; i < MAX_TRAITS; i++) begin
         pend_row[i] = '0;
         for (int k = 0; k < MAX_ROWS; k++) kept_store[k][i] = '0;
      end
   end

   function automatic void screen_element(input logic [TRAIT_W-1:0] trait,
                                          input logic [ABUND_W-1:0] abund,
                                          input bit row_end, input bit set_end,
                                          output bit emits, output row_verdict_type v);
      logic [63:0] sum;
      logic [63:0] diff;
      logic [63:0] limit;
      int          n;
      bit          uniq;
      v = '0;
      if (elems_in_row < MAX_TRAITS) begin
         pend_row[elems_in_row] = trait;
         elems_in_row++;
      end
      emits = row_end || set_end;
      if (!emits) return;
      n = elems_in_row;
      if (rows_in_set >= MAX_ROWS) begin
         v.overflow = 1'b1;
      end else begin
         v.row_index = rows_in_set[INDEX_W-1:0];
         rows_in_set++;
         uniq  = 1'b1;
         limit = 64'(n) * 64'(precision_sq);
         for (int k = 0; k < kept_n; k++) begin
            sum = '0;
            for (int i = 0; i < n; i++) begin
               diff = (pend_row[i] >= kept_store[k][i])
                      ? 64'(pend_row[i] - kept_store[k][i])
                      : 64'(kept_store[k][i] - pend_row[i]);
               sum += diff * diff;
            end
            if (sum < limit) begin
               uniq = 1'b0;
               break;
            end
         end
         if (uniq && kept_n < MAX_ROWS) begin
            for (int i = 0; i < MAX_TRAITS; i++)
               kept_store[kept_n][i] = (i < n) ? pend_row[i] : '0;
            kept_n++;
         end
         v.is_unique = uniq;
         v.keep      = uniq && (abund > abundance_floor);
      end
      v.set_done   = set_end;
      elems_in_row = 0;
      if (set_end) begin
         kept_n      = 0;
         rows_in_set = 0;
      end
   endfunction

   function automatic logic [TRAIT_W-1:0] nudge(input logic [TRAIT_W-1:0] v, input int spread);
      int t;
      t = int'(v) + int'($urandom_range(0, 2 * spread)) - spread;
      if (t < 0) t = 0;
      else if (t > 24'hFFFFFF) t = 24'hFFFFFF;
      return t[TRAIT_W-1:0];
   endfunction

   function automatic logic [ABUND_W-1:0] pick_abundance();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return {16'($urandom), 32'($urandom)};
         4:          return abundance_floor;
         5:          return abundance_floor + 1'b1;
         6:          return abundance_floor - 1'b1;
         7:          return '0;
         8:          return '1;
         default:    return ABUND_W'($urandom_range(0, 200000));
      endcase
   endfunction

   task automatic stage(input logic [TRAIT_W-1:0] t, input logic [ABUND_W-1:0] a,
                        input bit re, input bit se, input bit typed,
                        input logic [INDEX_W-1:0] idx, input bit u, input bit k,
                        input bit o, input bit d);
      script_step_type s;
      s.trait   = t;
      s.abund   = a;
      s.row_end = re;
      s.set_end = se;
      s.typed   = typed;
      s.verdict = '{row_index: idx, is_unique: u, keep: k, overflow: o, set_done: d};
      script.push_back(s);
   endtask

   task automatic send_element(input logic [TRAIT_W-1:0] trait,
                               input logic [ABUND_W-1:0] abund,
                               input bit row_end, input bit set_end,
                               input bit typed, input row_verdict_type typed_verdict);
      bit              emits;
      row_verdict_type v;
      if (lull_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {abund, trait};
      req_tlast  <= row_end;
      req_tuser  <= set_end;
      do @(posedge clock); while (!req_tready);
      screen_element(trait, abund, row_end, set_end, emits, v);
      if (emits) verdicts_due.push_back(typed ? typed_verdict : v);
      @(negedge clock);
   endtask

   task automatic settle(input int cycles);
      req_tvalid <= 1'b0;
      while (verdicts_due.size() != 0) @(negedge clock);
      repeat (cycles) @(negedge clock);
   endtask

   task automatic program_filter(input logic [CSR_W-1:0] prec, input logic [CSR_W-1:0] floor_val);
      csr_we    <= 1'b1;
      csr_index <= CSR_PRECISION_SQ;
      csr_wdata <= prec;
      @(negedge clock);
      precision_sq = prec;
      csr_index <= CSR_ABUNDANCE_FLOOR;
      csr_wdata <= floor_val;
      @(negedge clock);
      abundance_floor = floor_val;
      csr_we <= 1'b0;
   endtask

   task automatic send_set(input int n_rows, input bit short_rows);
      logic [TRAIT_W-1:0] base [4][MAX_TRAITS];
      int                 base_len [4];
      int                 pick;
      int                 len;
      int                 kind;
      int                 spread;
      int                 max_len;
      logic [TRAIT_W-1:0] val;
      bit                 last_row;
      bit                 ends;
      max_len = short_rows ? 2 : MAX_TRAITS;
      for (int b = 0; b < 4; b++) begin
         base_len[b] = $urandom_range(1, max_len);
         for (int i = 0; i < MAX_TRAITS; i++) base[b][i] = 24'($urandom);
      end
      for (int r = 0; r < n_rows; r++) begin
         pick     = $urandom_range(0, 3);
         len      = ($urandom_range(0, 9) < 8) ? base_len[pick]
                                               : $urandom_range(1, short_rows ? 2 : MAX_TRAITS + 2);
         kind     = $urandom_range(0, 9);
         spread   = $urandom_range(0, 1500);
         last_row = (r == n_rows - 1);
         for (int e = 0; e < len; e++) begin
            case (kind)
               0, 1, 2, 3, 4, 5: val = nudge(base[pick][e % MAX_TRAITS], spread);
               8:                val = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
               9:                val = base[pick][e % MAX_TRAITS];
               default:          val = 24'($urandom);
            endcase
            ends = (e == len - 1);
            send_element(val, pick_abundance(),
                         ends && !(last_row && $urandom_range(0, 3) == 0),
                         ends && last_row, 1'b0, '0);
            if (e < MAX_TRAITS) elements_sent++;
         end
      end
      sets_sent++;
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (stall_left == 0 && lull_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 7);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_verdict.row_index = rsp_tdata[INDEX_W-1:0];
         seen_verdict.is_unique = rsp_tuser[0];
         seen_verdict.keep      = rsp_tuser[1];
         seen_verdict.overflow  = rsp_tuser[2];
         seen_verdict.set_done  = rsp_tlast;
         if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected row verdict idx=%0d uniq=%0b keep=%0b ovf=%0b done=%0b",
                     $time, seen_verdict.row_index, seen_verdict.is_unique, seen_verdict.keep,
                     seen_verdict.overflow, seen_verdict.set_done);
            errors++;
         end else begin
            want_verdict = verdicts_due.pop_front();
            verdicts_checked++;
            if (seen_verdict.overflow) overflows_seen++;
            if (seen_verdict.row_index !== want_verdict.row_index ||
                seen_verdict.is_unique !== want_verdict.is_unique ||
                seen_verdict.keep      !== want_verdict.keep ||
                seen_verdict.overflow  !== want_verdict.overflow ||
                seen_verdict.set_done  !== want_verdict.set_done) begin
               $display("%0t: row verdict mismatch: expected idx=%0d uniq=%0b keep=%0b",
                        $time, want_verdict.row_index, want_verdict.is_unique,
                        want_verdict.keep,
                        " ovf=%0b done=%0b, actual idx=%0d uniq=%0b keep=%0b",
                        want_verdict.overflow, want_verdict.set_done,
                        seen_verdict.row_index, seen_verdict.is_unique, seen_verdict.keep,
                        " ovf=%0b done=%0b",
                        seen_verdict.overflow, seen_verdict.set_done);
               errors++;
            end
         end
      end
   end

   initial begin
      #(80_000_000);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic [CSR_W-1:0] prec_next;
      logic [CSR_W-1:0] floor_next;
      int               phase_start;

      stage(24'h000000, 48'h0,            1, 0, 1, 6'd0, 1, 0, 0, 0);
      stage(24'h000000, 48'hFFFFFFFFFFFF, 1, 0, 1, 6'd1, 0, 0, 0, 0);
      stage(24'hFFFFFF, 48'd42951,        1, 0, 1, 6'd2, 1, 1, 0, 0);
      stage(24'hFFFFFF, 48'd42950,        1, 0, 1, 6'd3, 0, 0, 0, 0);
      // overlong row: ninth element is dropped
      for (int i = 0; i < MAX_TRAITS + 1; i++)
         stage(24'h123456 + 24'(i) * 24'h0F0F0F, 48'h800000000000,
               i == MAX_TRAITS, 0, 0, '0, 0, 0, 0, 0);
      stage(24'h000000, 48'h0,            0, 0, 0, '0,   0, 0, 0, 0);
      stage(24'h000000, 48'h0,            1, 0, 1, 6'd5, 0, 0, 0, 0);
      stage(24'h800000, 48'h800000000000, 0, 1, 0, '0,   0, 0, 0, 0);
      stage(24'h000000, 48'd42951,        1, 0, 1, 6'd0, 1, 1, 0, 0);
      stage(24'h000100, 48'h0,            1, 1, 1, 6'd1, 0, 0, 0, 1);

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (script[s])
         send_element(script[s].trait, script[s].abund, script[s].row_end,
                      script[s].set_end, script[s].typed, script[s].verdict);
      settle(SETTLE_CYCLES);

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin
               prec_next  = '0;
               floor_next = '0;
            end
            1: begin
               prec_next  = '1;
               floor_next = '1;
            end
            2: begin
               prec_next  = CSR_W'($urandom_range(0, 1 << 21));
               floor_next = CSR_W'($urandom_range(0, 1 << 20));
            end
            3: begin
               prec_next  = PRECISION_SQ_RESET;
               floor_next = {16'($urandom), 32'($urandom)};
            end
            default: begin
               prec_next  = CSR_W'($urandom_range(1 << 16, 1 << 22));
               floor_next = CSR_W'($urandom);
            end
         endcase
         program_filter(prec_next, floor_next);
         lull_on     = (p < 4);
         phase_start = elements_sent;
         // long set with short rows to run past the row store capacity
         if (p == 2) send_set($urandom_range(MAX_ROWS + 2, MAX_ROWS + 6), 1'b1);
         while (elements_sent - phase_start < PHASE_ITEMS)
            send_set($urandom_range(1, 12), 1'b0);
         settle((p < 4) ? SETTLE_CYCLES : TAIL_CYCLES);
      end

      $display("Sent %0d trait elements in %0d sets across six register settings.",
               elements_sent + script.size(), sets_sent + 2);
      $display("Checked %0d row verdicts, %0d of them past the row store capacity.",
               verdicts_checked, overflows_seen);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
